// File: rtl/pcpe_pkg.sv
package pcpe_pkg;

    // Palette and lookup sizes
    localparam int NUM_PALETTES = 4;
    localparam int CLUT_DEPTH   = 256;
    localparam int CLUT_ADDR_W  = 8;
    localparam int PAL_SEL_W    = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
    localparam int PAL_DEPTH    = NUM_PALETTES * CLUT_DEPTH;
    localparam int PAL_ADDR_W   = PAL_SEL_W + CLUT_ADDR_W;

    // Action codes
    localparam logic [1:0] ACT_PAL_WRITE  = 2'd0;
    localparam logic [1:0] ACT_CLUT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TRANSLATE  = 2'd2;
    localparam logic [1:0] ACT_RESERVED   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_BIT_DEPTH    = 3'd0;
    localparam logic [2:0] CFG_COLOR_INDEX  = 3'd1;
    localparam logic [2:0] CFG_SEL_PALETTE  = 3'd2;
    localparam logic [2:0] CFG_RED_LAYOUT   = 3'd3;
    localparam logic [2:0] CFG_GREEN_LAYOUT = 3'd4;
    localparam logic [2:0] CFG_BLUE_LAYOUT  = 3'd5;
    localparam logic [2:0] CFG_ALPHA_LAYOUT = 3'd6;

    // Output depth codes
    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;
    localparam logic [1:0] DEPTH_24 = 2'd2;
    localparam logic [1:0] DEPTH_32 = 2'd3;

    // Register reset values
    localparam logic [8:0] RST_RED_LAYOUT   = 9'd264;
    localparam logic [8:0] RST_GREEN_LAYOUT = 9'd136;
    localparam logic [8:0] RST_BLUE_LAYOUT  = 9'd8;
    localparam logic [8:0] RST_ALPHA_LAYOUT = 9'd392;

    localparam logic [3:0] MAX_CHAN_BITS = 4'd8;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] palette_select;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] pixel_index;
        logic       end_of_run;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [2:0]  pixel_bytes;
        logic        line_end;
    } t_out_item;

    typedef struct packed {
        logic [1:0] bit_depth_mode;
        logic       color_index_mode;
        logic [2:0] selected_palette;
        logic [8:0] red_layout;
        logic [8:0] green_layout;
        logic [8:0] blue_layout;
        logic [8:0] alpha_layout;
    } t_cfg;

    typedef struct packed {
        logic                   en;
        logic [CLUT_ADDR_W-1:0] addr;
        logic [31:0]            data;
    } t_clut_wr;

    // Keep the top bits of one channel and place them at its shift
    function automatic logic [31:0] pack_channel(input logic [7:0] c, input logic [8:0] layout);
        logic [3:0]  bits;
        logic [7:0]  top;
        logic [31:0] word;
        bits = (layout[3:0] > MAX_CHAN_BITS) ? MAX_CHAN_BITS : layout[3:0];
        top  = c >> (MAX_CHAN_BITS - bits);
        word = {24'd0, top};
        return word << layout[8:4];
    endfunction

    function automatic logic pal_sel_ok(input logic [3:0] sel);
        return int'(sel) < NUM_PALETTES;
    endfunction

    function automatic logic [PAL_ADDR_W-1:0] pal_addr(input logic [3:0] sel,
                                                      input logic [7:0] idx);
        return {sel[PAL_SEL_W-1:0], idx};
    endfunction

    // Clear bytes above the output depth
    function automatic logic [31:0] mask_pixel(input logic [31:0] v, input logic [1:0] depth);
        logic [31:0] m;
        case (depth)
            DEPTH_8:  m = {24'd0, v[7:0]};
            DEPTH_16: m = {16'd0, v[15:0]};
            DEPTH_24: m = {8'd0, v[23:0]};
            DEPTH_32: m = v;
            default:  m = v;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/pcpe_cfg_regs.sv
module pcpe_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [8:0]    i_cfg_wdata,
    output pcpe_pkg::t_cfg o_cfg
);

    pcpe_pkg::t_cfg r_cfg;

    // Load the addressed register; ignore indexes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_depth_mode   <= pcpe_pkg::DEPTH_32;
            r_cfg.color_index_mode <= 1'b0;
            r_cfg.selected_palette <= 3'd0;
            r_cfg.red_layout       <= pcpe_pkg::RST_RED_LAYOUT;
            r_cfg.green_layout     <= pcpe_pkg::RST_GREEN_LAYOUT;
            r_cfg.blue_layout      <= pcpe_pkg::RST_BLUE_LAYOUT;
            r_cfg.alpha_layout     <= pcpe_pkg::RST_ALPHA_LAYOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcpe_pkg::CFG_BIT_DEPTH:    r_cfg.bit_depth_mode   <= i_cfg_wdata[1:0];
                pcpe_pkg::CFG_COLOR_INDEX:  r_cfg.color_index_mode <= i_cfg_wdata[0];
                pcpe_pkg::CFG_SEL_PALETTE:  r_cfg.selected_palette <= i_cfg_wdata[2:0];
                pcpe_pkg::CFG_RED_LAYOUT:   r_cfg.red_layout       <= i_cfg_wdata;
                pcpe_pkg::CFG_GREEN_LAYOUT: r_cfg.green_layout     <= i_cfg_wdata;
                pcpe_pkg::CFG_BLUE_LAYOUT:  r_cfg.blue_layout      <= i_cfg_wdata;
                pcpe_pkg::CFG_ALPHA_LAYOUT: r_cfg.alpha_layout     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/pcpe_palette.sv
module pcpe_palette (
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic               i_accept,
    input  pcpe_pkg::t_in_item i_item,
    input  pcpe_pkg::t_cfg     i_cfg,
    output logic [31:0]        o_rd_data
);

    logic [31:0]                     r_mem [pcpe_pkg::PAL_DEPTH];
    logic [31:0]                     r_rd_data;
    logic [31:0]                     w_word;
    logic                            w_wr_en;
    logic [pcpe_pkg::PAL_ADDR_W-1:0] w_wr_addr;
    logic [pcpe_pkg::PAL_ADDR_W-1:0] w_rd_addr;

    // Pack the four channels into one word
    assign w_word = pcpe_pkg::pack_channel(i_item.red,   i_cfg.red_layout)
                  | pcpe_pkg::pack_channel(i_item.green, i_cfg.green_layout)
                  | pcpe_pkg::pack_channel(i_item.blue,  i_cfg.blue_layout)
                  | pcpe_pkg::pack_channel(i_item.alpha, i_cfg.alpha_layout);

    // Drop writes to palettes that do not exist
    assign w_wr_en   = i_accept && (i_item.action == pcpe_pkg::ACT_PAL_WRITE)
                    && pcpe_pkg::pal_sel_ok({2'b00, i_item.palette_select});
    assign w_wr_addr = pcpe_pkg::pal_addr({2'b00, i_item.palette_select}, i_item.entry_index);
    assign w_rd_addr = pcpe_pkg::pal_addr({1'b0, i_cfg.selected_palette}, i_item.pixel_index);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_word;
        end
    end

    // Read for a lookup fill in the same cycle the transaction is taken
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pcpe_clut.sv
module pcpe_clut (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic [pcpe_pkg::CLUT_ADDR_W-1:0]    i_rd_addr,
    input  pcpe_pkg::t_clut_wr                  i_wr,
    output logic [31:0]                         o_rd_data
);

    logic [31:0]                      r_mem [pcpe_pkg::CLUT_DEPTH];
    logic [pcpe_pkg::CLUT_DEPTH-1:0]  r_valid;
    logic [31:0]                      r_rd_data;
    logic                             r_rd_valid;
    logic                             r_fwd_hit;
    logic [31:0]                      r_fwd_data;

    // Mark entries as written; reset empties the whole table at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read, and catch a write to the same entry in this cycle
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
            r_fwd_hit  <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_fwd_data <= i_wr.data;
        end
    end

    // Unwritten entries read as zero
    assign o_rd_data = r_fwd_hit  ? r_fwd_data :
                       r_rd_valid ? r_rd_data  : 32'd0;

endmodule

// File: rtl/palette_clut_pixel_expander_unit.sv
// Palette and color lookup pixel expander.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries palette writes,
// lookup writes and pixels to translate; only translates produce a transaction
// on the output channel (o_out_valid / i_out_stall / o_out_data).
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must
// write it only while the block holds no work, which the block does not enforce.
// Throughput: one transaction per clock while o_in_stall is low. A translated
// pixel passes the lookup read at intake and then the result register before it
// shows on o_out_valid.
// A lookup write reads the palette at intake and updates the lookup from the first
// stage; a translate of the same entry may follow it directly, and the new value
// is forwarded.
// Reset clears the output register, the pipeline and every lookup entry at
// once; palette contents are undefined until written.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_in_stall rises in the same cycle; it falls again once the result is taken.
module palette_clut_pixel_expander_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pcpe_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pcpe_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [8:0]          i_cfg_wdata
);

    pcpe_pkg::t_cfg      w_cfg;
    pcpe_pkg::t_clut_wr  w_clut_wr;
    pcpe_pkg::t_out_item n_out_data;
    logic                w_adv;
    logic                w_accept;
    logic [31:0]         w_pal_rd;
    logic [31:0]         w_clut_rd;

    logic                r_s1_valid;
    logic [1:0]          r_s1_action;
    logic [7:0]          r_s1_entry;
    logic [7:0]          r_s1_pixel;
    logic                r_s1_eor;
    logic                r_out_valid;
    pcpe_pkg::t_out_item r_out_data;

    // Pipeline moves unless a result waits on a stalled receiver
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && w_adv;
    assign o_in_stall = !w_adv;

    pcpe_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    pcpe_palette u_palette (
        .i_clk     (i_clk),
        .i_adv     (w_adv),
        .i_accept  (w_accept),
        .i_item    (i_in_data),
        .i_cfg     (w_cfg),
        .o_rd_data (w_pal_rd)
    );

    // Capture the transaction in the first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_action <= i_in_data.action;
            r_s1_entry  <= i_in_data.entry_index;
            r_s1_pixel  <= i_in_data.pixel_index;
            r_s1_eor    <= i_in_data.end_of_run;
        end
    end

    // Fill the lookup from the byte itself or from the palette
    always_comb begin
        w_clut_wr.en   = w_adv && r_s1_valid && (r_s1_action == pcpe_pkg::ACT_CLUT_WRITE)
                      && pcpe_pkg::pal_sel_ok({1'b0, w_cfg.selected_palette});
        w_clut_wr.addr = r_s1_entry;
        w_clut_wr.data = w_cfg.color_index_mode ? {24'd0, r_s1_pixel} : w_pal_rd;
    end

    pcpe_clut u_clut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_rd_addr (i_in_data.pixel_index),
        .i_wr      (w_clut_wr),
        .o_rd_data (w_clut_rd)
    );

    // Trim the looked-up color to the output depth
    always_comb begin
        n_out_data.pixel_value = pcpe_pkg::mask_pixel(w_clut_rd, w_cfg.bit_depth_mode);
        n_out_data.pixel_bytes = {1'b0, w_cfg.bit_depth_mode} + 3'd1;
        n_out_data.line_end    = r_s1_eor;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid && (r_s1_action == pcpe_pkg::ACT_TRANSLATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/pcpe_checker.sv
module pcpe_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pcpe_pkg::t_out_item o_out_data
);

    // Input is held back only while a result waits on a stalled receiver
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a waiting result");

    // Byte count stays within one to four
    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pixel_bytes != 3'd0 && o_out_data.pixel_bytes <= 3'd4))
        else $error("pixel byte count out of range");

    // Bytes above the reported depth are zero
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.pixel_bytes != 3'd1 || o_out_data.pixel_value[31:8] == 24'd0)
                      && (o_out_data.pixel_bytes != 3'd2 || o_out_data.pixel_value[31:16] == 16'd0)
                      && (o_out_data.pixel_bytes != 3'd3 || o_out_data.pixel_value[31:24] == 8'd0)))
        else $error("pixel bits set above output depth");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output transaction changed");

endmodule

bind palette_clut_pixel_expander_unit pcpe_checker u_pcpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: bench/palette_clut_pixel_expander_unit_checker.sv
`timescale 1ns / 1ps

module palette_clut_pixel_expander_unit_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  pcpe_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  pcpe_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [8:0]          i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending
);

    // Shadow copy of the lookup, the palettes and the registers
    logic [31:0] lookup_words  [pcpe_pkg::CLUT_DEPTH];
    logic [31:0] palette_words [pcpe_pkg::PAL_DEPTH];
    logic [1:0]  depth_mode;
    logic        index_mode;
    logic [2:0]  clut_source;
    logic [8:0]  red_lay;
    logic [8:0]  green_lay;
    logic [8:0]  blue_lay;
    logic [8:0]  alpha_lay;

    pcpe_pkg::t_out_item expected_pixels [$];
    int                  mismatches     = 0;
    int                  pending_pixels = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_pixels;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Keep the top bits of one channel, then place them at the channel shift
    function automatic logic [31:0] pack_lane(input logic [7:0] c, input logic [8:0] layout);
        int          kept;
        logic [31:0] w;
        kept = (layout[3:0] > 4'd8) ? 8 : int'(layout[3:0]);
        w = {24'd0, c} >> (8 - kept);
        return w << layout[8:4];
    endfunction

    // Look the pixel up and clear the bytes above the output depth
    function automatic pcpe_pkg::t_out_item predict_pixel(input logic [7:0] pix,
                                                          input logic eor);
        pcpe_pkg::t_out_item res;
        logic [31:0]         v;
        int                  nbytes;
        v = lookup_words[pix];
        nbytes = int'(depth_mode) + 1;
        if (nbytes < 4) begin
            v = v & ((32'd1 << (8 * nbytes)) - 32'd1);
        end
        res.pixel_value = v;
        res.pixel_bytes = 3'(nbytes);
        res.line_end    = eor;
        return res;
    endfunction

    task automatic apply_reg(input logic [2:0] idx, input logic [8:0] wdata);
        case (idx)
            pcpe_pkg::CFG_BIT_DEPTH:    depth_mode  = wdata[1:0];
            pcpe_pkg::CFG_COLOR_INDEX:  index_mode  = wdata[0];
            pcpe_pkg::CFG_SEL_PALETTE:  clut_source = wdata[2:0];
            pcpe_pkg::CFG_RED_LAYOUT:   red_lay     = wdata;
            pcpe_pkg::CFG_GREEN_LAYOUT: green_lay   = wdata;
            pcpe_pkg::CFG_BLUE_LAYOUT:  blue_lay    = wdata;
            pcpe_pkg::CFG_ALPHA_LAYOUT: alpha_lay   = wdata;
            default: ;
        endcase
    endtask

    task automatic apply_item(input pcpe_pkg::t_in_item it);
        int pal_idx;
        case (it.action)
            pcpe_pkg::ACT_PAL_WRITE: begin
                if (int'(it.palette_select) < pcpe_pkg::NUM_PALETTES) begin
                    pal_idx = int'(it.palette_select) * pcpe_pkg::CLUT_DEPTH
                            + int'(it.entry_index);
                    palette_words[pal_idx] = pack_lane(it.red, red_lay)
                                           | pack_lane(it.green, green_lay)
                                           | pack_lane(it.blue, blue_lay)
                                           | pack_lane(it.alpha, alpha_lay);
                end
            end
            pcpe_pkg::ACT_CLUT_WRITE: begin
                // Out-of-range palette drops the fill in both modes
                if (int'(clut_source) < pcpe_pkg::NUM_PALETTES) begin
                    pal_idx = int'(clut_source) * pcpe_pkg::CLUT_DEPTH + int'(it.pixel_index);
                    lookup_words[it.entry_index] = index_mode ? {24'd0, it.pixel_index}
                                                              : palette_words[pal_idx];
                end
            end
            pcpe_pkg::ACT_TRANSLATE: begin
                expected_pixels.push_back(predict_pixel(it.pixel_index, it.end_of_run));
            end
            default: ;
        endcase
    endtask

    // Watch both channels and the register port on every edge
    always @(posedge i_clk) begin : watch
        pcpe_pkg::t_out_item want;
        if (!i_rst_n) begin
            depth_mode  = pcpe_pkg::DEPTH_32;
            index_mode  = 1'b0;
            clut_source = 3'd0;
            red_lay     = pcpe_pkg::RST_RED_LAYOUT;
            green_lay   = pcpe_pkg::RST_GREEN_LAYOUT;
            blue_lay    = pcpe_pkg::RST_BLUE_LAYOUT;
            alpha_lay   = pcpe_pkg::RST_ALPHA_LAYOUT;
            for (int i = 0; i < pcpe_pkg::CLUT_DEPTH; i++) lookup_words[i] = '0;
            for (int i = 0; i < pcpe_pkg::PAL_DEPTH; i++) palette_words[i] = '0;
            expected_pixels.delete();
        end else begin
            // Compare the oldest expectation with the result transaction
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("result with none expected, value %h",
                                              i_out_data.pixel_value));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_data.pixel_value !== want.pixel_value)
                        report_mismatch($sformatf("pixel_value got %h expected %h",
                                                  i_out_data.pixel_value, want.pixel_value));
                    if (i_out_data.pixel_bytes !== want.pixel_bytes)
                        report_mismatch($sformatf("pixel_bytes got %0d expected %0d",
                                                  i_out_data.pixel_bytes, want.pixel_bytes));
                    if (i_out_data.line_end !== want.line_end)
                        report_mismatch($sformatf("line_end got %b expected %b",
                                                  i_out_data.line_end, want.line_end));
                end
            end
            if (i_cfg_we) begin
                apply_reg(i_cfg_idx, i_cfg_wdata);
            end
            if (i_in_valid && !i_in_stall) begin
                apply_item(i_in_data);
            end
        end
        pending_pixels <= expected_pixels.size();
    end

endmodule

// File: bench/palette_clut_pixel_expander_unit_tb.sv
`timescale 1ns / 1ps

module palette_clut_pixel_expander_unit_tb;

    localparam int NUM_CFG_REGS    = 7;
    localparam int DRAIN_SLACK     = 6;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 100;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    pcpe_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    pcpe_pkg::t_out_item o_out_data;
    logic                i_cfg_we;
    logic [2:0]          i_cfg_idx;
    logic [8:0]          i_cfg_wdata;

    int         fail_count;
    int         pending;

    // Stimulus bookkeeping
    pcpe_pkg::t_cfg cur_cfg;
    bit             pal_written [pcpe_pkg::PAL_DEPTH];
    int             burst_left = 0;
    int             item_count = 0;
    bit             hold_req   = 1'b0;
    bit             hold_done  = 1'b0;

    palette_clut_pixel_expander_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    palette_clut_pixel_expander_unit_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("palette_clut_pixel_expander_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    initial begin : receiver
        int seg_len;
        int seg_mode;
        i_out_stall <= 1'b0;
        forever begin
            seg_len  = $urandom_range(10, 80);
            seg_mode = $urandom_range(0, 3);
            for (int k = 0; k < seg_len; k++) begin
                @(posedge i_clk);
                if (hold_req && !hold_done) begin
                    hold_done = 1'b1;
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                case (seg_mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= k[0];
                endcase
            end
        end
    end

    function automatic pcpe_pkg::t_in_item build_item(input logic [1:0] act,
                                                      input logic [1:0] psel,
                                                      input logic [7:0] entry,
                                                      input logic [31:0] rgba,
                                                      input logic [7:0] pix,
                                                      input logic eor);
        pcpe_pkg::t_in_item it;
        it.action         = act;
        it.palette_select = psel;
        it.entry_index    = entry;
        it.red            = rgba[31:24];
        it.green          = rgba[23:16];
        it.blue           = rgba[15:8];
        it.alpha          = rgba[7:0];
        it.pixel_index    = pix;
        it.end_of_run     = eor;
        return it;
    endfunction

    // Offer one transaction in bursts with random gaps, hold until taken
    task automatic send_item(input pcpe_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if (it.action == pcpe_pkg::ACT_PAL_WRITE
            && int'(it.palette_select) < pcpe_pkg::NUM_PALETTES) begin
            pal_written[int'(it.palette_select) * pcpe_pkg::CLUT_DEPTH
                        + int'(it.entry_index)] = 1'b1;
        end
        if (it.action != pcpe_pkg::ACT_RESERVED) begin
            item_count++;
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Fill from a palette only where that palette entry holds a color
    task automatic send_clut_write(input logic [7:0] entry, input logic [7:0] pix,
                                   input logic eor);
        int src;
        src = int'(cur_cfg.selected_palette);
        if (!cur_cfg.color_index_mode && src < pcpe_pkg::NUM_PALETTES &&
            !pal_written[src * pcpe_pkg::CLUT_DEPTH + int'(pix)]) begin
            send_item(build_item(pcpe_pkg::ACT_PAL_WRITE, 2'(src), pix, $urandom,
                                 8'($urandom), 1'($urandom)));
        end
        send_item(build_item(pcpe_pkg::ACT_CLUT_WRITE, 2'($urandom), entry, $urandom, pix,
                             eor));
    endtask

    // Stop offering and wait for every pending pixel, then let the pipe settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic set_config(input pcpe_pkg::t_cfg cfg);
        logic [8:0] vals [NUM_CFG_REGS];
        drain_results();
        vals[pcpe_pkg::CFG_BIT_DEPTH]    = {7'd0, cfg.bit_depth_mode};
        vals[pcpe_pkg::CFG_COLOR_INDEX]  = {8'd0, cfg.color_index_mode};
        vals[pcpe_pkg::CFG_SEL_PALETTE]  = {6'd0, cfg.selected_palette};
        vals[pcpe_pkg::CFG_RED_LAYOUT]   = cfg.red_layout;
        vals[pcpe_pkg::CFG_GREEN_LAYOUT] = cfg.green_layout;
        vals[pcpe_pkg::CFG_BLUE_LAYOUT]  = cfg.blue_layout;
        vals[pcpe_pkg::CFG_ALPHA_LAYOUT] = cfg.alpha_layout;
        for (int r = 0; r < NUM_CFG_REGS; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= 3'(r);
            i_cfg_wdata <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_cfg = cfg;
    endtask

    function automatic pcpe_pkg::t_cfg make_config(input logic [1:0] depth,
                                                   input logic idx_mode,
                                                   input logic [2:0] sel,
                                                   input logic [8:0] r,
                                                   input logic [8:0] g,
                                                   input logic [8:0] b,
                                                   input logic [8:0] a);
        pcpe_pkg::t_cfg c;
        c.bit_depth_mode   = depth;
        c.color_index_mode = idx_mode;
        c.selected_palette = sel;
        c.red_layout       = r;
        c.green_layout     = g;
        c.blue_layout      = b;
        c.alpha_layout     = a;
        return c;
    endfunction

    // Phase settings: all low, all high, then random with mostly valid palettes
    function automatic pcpe_pkg::t_cfg phase_config(input int p);
        logic [2:0] sel;
        if (p == 0) return make_config(pcpe_pkg::DEPTH_8, 1'b0, 3'd0, '0, '0, '0, '0);
        if (p == 1) return make_config(pcpe_pkg::DEPTH_32, 1'b1, 3'd7, '1, '1, '1, '1);
        sel = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
        return make_config(2'($urandom), ($urandom_range(0, 3) == 0), sel, 9'($urandom),
                           9'($urandom), 9'($urandom), 9'($urandom));
    endfunction

    // One random sequence: mostly well-formed writes and lines, some noise
    task automatic run_sequence();
        int                 kind;
        int                 n;
        pcpe_pkg::t_in_item it;
        logic               eor;
        logic [7:0]         e;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_item(build_item(pcpe_pkg::ACT_PAL_WRITE, 2'($urandom), 8'($urandom),
                                         $urandom, 8'($urandom), 1'($urandom)));
            end
            2, 3: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_clut_write(8'($urandom), 8'($urandom), 1'($urandom));
            end
            8: begin
                // Fill an entry and read it back on the next transaction
                e = 8'($urandom);
                send_clut_write(e, 8'($urandom), 1'b0);
                send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'($urandom), 8'($urandom),
                                     $urandom, e, 1'($urandom)));
            end
            9: begin
                it = build_item(2'($urandom), 2'($urandom), 8'($urandom), $urandom,
                                8'($urandom), 1'($urandom));
                if (it.action == pcpe_pkg::ACT_CLUT_WRITE)
                    send_clut_write(it.entry_index, it.pixel_index, it.end_of_run);
                else
                    send_item(it);
            end
            default: begin
                // A line of pixels, marked at its last one, with an odd marker now and then
                n = $urandom_range(1, 16);
                for (int i = 0; i < n; i++) begin
                    eor = (i == n - 1);
                    if ($urandom_range(0, 9) == 0) eor = ~eor;
                    send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'($urandom), 8'($urandom),
                                         $urandom, 8'($urandom), eor));
                end
            end
        endcase
    endtask

    initial begin : stimulus
        int phase_end;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        cur_cfg = make_config(pcpe_pkg::DEPTH_32, 1'b0, 3'd0, pcpe_pkg::RST_RED_LAYOUT,
                              pcpe_pkg::RST_GREEN_LAYOUT, pcpe_pkg::RST_BLUE_LAYOUT,
                              pcpe_pkg::RST_ALPHA_LAYOUT);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Cleared lookup, palette extremes, fills from a palette, unused action
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd0, 8'd0, 32'h0, 8'd0, 1'b0));
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd3, 8'hff, 32'hffffffff, 8'hff, 1'b1));
        send_item(build_item(pcpe_pkg::ACT_PAL_WRITE, 2'd0, 8'd0, 32'hffffffff, 8'd0, 1'b0));
        send_item(build_item(pcpe_pkg::ACT_PAL_WRITE, 2'd0, 8'hff, 32'h12345678, 8'd0, 1'b1));
        send_item(build_item(pcpe_pkg::ACT_PAL_WRITE, 2'd3, 8'h80, 32'h8001fe7f, 8'd0, 1'b0));
        send_clut_write(8'hff, 8'd0, 1'b0);
        send_clut_write(8'd0, 8'hff, 1'b1);
        send_item(build_item(pcpe_pkg::ACT_RESERVED, 2'd3, 8'hff, 32'hffffffff, 8'hff, 1'b1));
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd0, 8'd0, 32'h0, 8'hff, 1'b0));
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd0, 8'd0, 32'h0, 8'd0, 1'b1));

        // Color-index fill, and the 24-bit depth cut to three bytes
        set_config(make_config(pcpe_pkg::DEPTH_24, 1'b1, 3'd3, pcpe_pkg::RST_RED_LAYOUT,
                               pcpe_pkg::RST_GREEN_LAYOUT, pcpe_pkg::RST_BLUE_LAYOUT,
                               pcpe_pkg::RST_ALPHA_LAYOUT));
        send_clut_write(8'd200, 8'hab, 1'b0);
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd0, 8'd0, 32'h0, 8'd200, 1'b0));
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd0, 8'd0, 32'h0, 8'd0, 1'b1));

        // Saturated count, zero count, shifts that push bits past the top
        set_config(make_config(pcpe_pkg::DEPTH_8, 1'b0, 3'd3, 9'h00f, 9'h1f0, 9'h1f4,
                               9'h1c8));
        send_item(build_item(pcpe_pkg::ACT_PAL_WRITE, 2'd3, 8'd9, 32'haa55ffc3, 8'd0, 1'b0));
        send_clut_write(8'd1, 8'd9, 1'b0);
        send_clut_write(8'd2, 8'h80, 1'b1);
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd0, 8'd0, 32'h0, 8'd1, 1'b0));

        // Fills from a palette that does not exist are dropped in both modes
        set_config(make_config(pcpe_pkg::DEPTH_16, 1'b0, 3'd4, 9'h00f, 9'h1f0, 9'h1f4,
                               9'h1c8));
        send_clut_write(8'd1, 8'd0, 1'b0);
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd0, 8'd0, 32'h0, 8'd1, 1'b1));
        set_config(make_config(pcpe_pkg::DEPTH_32, 1'b1, 3'd7, pcpe_pkg::RST_RED_LAYOUT,
                               pcpe_pkg::RST_GREEN_LAYOUT, pcpe_pkg::RST_BLUE_LAYOUT,
                               pcpe_pkg::RST_ALPHA_LAYOUT));
        send_clut_write(8'd2, 8'h55, 1'b0);
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd0, 8'd0, 32'h0, 8'd2, 1'b0));
        send_item(build_item(pcpe_pkg::ACT_TRANSLATE, 2'd0, 8'd0, 32'h0, 8'd1, 1'b1));

        // Random phases, each under its own setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_config(phase_config(p));
            if (p == 2) hold_req = 1'b1;
            phase_end = item_count + ITEMS_PER_PHASE;
            while (item_count < phase_end) run_sequence();
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("palette_clut_pixel_expander_unit_tb OK");
        end else begin
            $display("palette_clut_pixel_expander_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
